// ===== hdl/rle_pkg.sv =====
// shared types and constants for the run-length expander
// used by rle_ctrl, rle_dp and run_length_expand
package rle_pkg;

  localparam int unsigned MAX_RUN = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

  typedef enum logic [1:0] {
    KIND_ELEMENT = 2'd0,
    KIND_MARKER  = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] value;
    logic              job_first;
    logic              job_last;
  } rle_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    kind_e             kind;
    logic              run_end;
    logic              job_end;
  } rle_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } rle_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic multi;
    logic rem_one;
  } rle_stat_t;

endpackage

// ===== hdl/rle_dp.sv =====
// datapath of the run-length expander: offsets, error flag, run counter and output word
// depends on rle_pkg
module rle_dp
  import rle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  rle_in_t   in_word_i,
  input  logic      out_stall_i,
  input  rle_cmd_t  cmd_i,
  output rle_stat_t stat_o,
  output logic      out_valid_o,
  output rle_out_t  out_word_o
);

  logic              cum_q;
  logic [DATA_W-1:0] prev_q, prev_d;
  logic              err_q, err_d;
  logic [RUN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  rle_out_t          out_q, out_d;

  logic              drop;
  logic              bad;
  logic [DATA_W-1:0] run;
  logic [RUN_W-1:0]  run_s;
  logic              item_err;
  logic              item_marker;
  logic              item_elem;

  // classify the incoming word
  always_comb begin
    drop = !in_word_i.job_first && err_q;
    bad  = 1'b0;
    run  = in_word_i.count;
    if (cum_q) begin
      if (in_word_i.job_first) begin
        run = '0;
      end else if (in_word_i.count < prev_q) begin
        bad = 1'b1;
      end else begin
        run = in_word_i.count - prev_q;
      end
    end
    run_s       = run[RUN_W-1:0];
    item_err    = !drop && (bad || (run > DATA_W'(MAX_RUN)));
    item_marker = !drop && !item_err && (run == '0) && in_word_i.job_last;
    item_elem   = !drop && !item_err && (run != '0);
  end

  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.multi     = item_elem && (run_s > RUN_W'(1));
  assign stat_o.rem_one   = (rem_q == RUN_W'(1));

  always_comb begin
    prev_d      = prev_q;
    err_d       = err_q;
    rem_d       = rem_q;
    val_d       = val_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load && !drop) begin
      err_d = 1'b0;
      if (cum_q && !bad) begin
        prev_d = in_word_i.count;
      end
      if (item_err) begin
        err_d       = 1'b1;
        out_valid_d = 1'b1;
        out_d       = '{element: '0, kind: KIND_ERROR, run_end: 1'b1, job_end: 1'b1};
      end else if (item_marker) begin
        out_valid_d = 1'b1;
        out_d       = '{element: '0, kind: KIND_MARKER, run_end: 1'b1, job_end: 1'b1};
      end else if (item_elem) begin
        out_valid_d = 1'b1;
        out_d       = '{element: in_word_i.value, kind: KIND_ELEMENT,
                        run_end: (run_s == RUN_W'(1)),
                        job_end: (run_s == RUN_W'(1)) && in_word_i.job_last};
        rem_d       = run_s - RUN_W'(1);
        val_d       = in_word_i.value;
        last_d      = in_word_i.job_last;
      end
    end else if (cmd_i.step) begin
      out_valid_d = 1'b1;
      out_d       = '{element: val_q, kind: KIND_ELEMENT,
                      run_end: stat_o.rem_one, job_end: stat_o.rem_one && last_q};
      rem_d       = rem_q - RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q       <= 1'b0;
      prev_q      <= '0;
      err_q       <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cum_q <= cfg_data_i;
      end
      prev_q      <= prev_d;
      err_q       <= err_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hdl/rle_ctrl.sv =====
// controller of the run-length expander: takes words and steps through runs
// depends on rle_pkg
module rle_ctrl
  import rle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rle_stat_t stat_i,
  output rle_cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !stat_i.slot_free;
        cmd_o.load = in_valid_i && stat_i.slot_free;
      end
      ST_RUN: begin
        cmd_o.step = stat_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load && stat_i.multi) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_o.step && stat_i.rem_one) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/run_length_expand.sv =====
// run-length expander top level: controller plus datapath
// depends on rle_pkg, rle_ctrl and rle_dp
//
// Each input word (count, value) expands into count output words of value,
// one per cycle unless the output stalls; in cumulative mode the run is the
// difference to the previous offset and a job's first word only loads it,
// plus a marker if it also ends the job. A word with one or no output
// (marker, error, dropped or empty run) is handled in idle; longer runs
// leave the single output register one element at a time. The next word can
// be taken once the controller is idle after the run's last element, which
// may still wait in the output register. Runs above MAX_RUN or decreasing
// offsets give one error word and the job is dropped until the next job_first.
module run_length_expand
  import rle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rle_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rle_out_t out_word_o
);

  rle_cmd_t  cmd;
  rle_stat_t stat;

  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== tb/run_length_expand_test.sv =====
// self-checking testbench for run_length_expand: directed table plus random jobs
// predicts every output word from its own model of the expander or from the directed table; needs rle_pkg
module run_length_expand_test
  import rle_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 600000;

  typedef struct packed {
    logic        mode;
    logic [31:0] count;
    logic [31:0] value;
    logic        first;
    logic        last;
    logic        typed;
    logic        one;
    kind_e       kind;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic     cfg_data_i;
  logic     in_valid_i;
  logic     in_stall_o;
  rle_in_t  in_word_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rle_out_t out_word_o;

  run_length_expand dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // predictor state
  logic        cum_mode;
  logic [31:0] last_offset;
  logic        drop_job;
  int          live_items;

  rle_out_t elements_due[$];
  dir_row_t dir_rows [25];

  int failures;
  int cycles;
  int tx_idle_pct;
  int rx_stall_pct;
  logic hold_req;
  logic hold_ack;
  int hold_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL run_length_expand");
      $finish;
    end
  end

  function automatic rle_out_t closing_word(input kind_e k);
    rle_out_t r;
    r.element = '0;
    r.kind    = k;
    r.run_end = 1'b1;
    r.job_end = 1'b1;
    return r;
  endfunction

  function automatic void expand_run(input rle_in_t w, ref rle_out_t res[$]);
    logic [31:0] run;
    rle_out_t    r;
    int          k;
    if (w.job_first) begin
      drop_job = 1'b0;
    end else if (drop_job) begin
      return;
    end
    live_items++;
    if (cum_mode) begin
      if (w.job_first) begin
        last_offset = w.count;
        run = '0;
      end else if (w.count < last_offset) begin
        drop_job = 1'b1;
        res.push_back(closing_word(KIND_ERROR));
        return;
      end else begin
        run = w.count - last_offset;
        last_offset = w.count;
      end
    end else begin
      run = w.count;
    end
    if (run > MAX_RUN) begin
      drop_job = 1'b1;
      res.push_back(closing_word(KIND_ERROR));
      return;
    end
    if (run == 0) begin
      if (w.job_last) res.push_back(closing_word(KIND_MARKER));
      return;
    end
    for (k = int'(run); k > 0; k--) begin
      r.element = w.value;
      r.kind    = KIND_ELEMENT;
      r.run_end = (k == 1);
      r.job_end = (k == 1) && w.job_last;
      res.push_back(r);
    end
  endfunction

  task automatic offer_word(input rle_in_t w, input logic typed, input logic one,
                            input kind_e kind);
    rle_out_t res[$];
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_word_i  = w;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expand_run(w, res);
    if (typed) begin
      res.delete();
      if (one) res.push_back(closing_word(kind));
    end
    foreach (res[k]) elements_due.push_back(res[k]);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (elements_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_we_i   = 1'b1;
    cfg_data_i = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cum_mode = m;
  endtask

  task automatic send_job();
    int          n_items;
    int          sel;
    logic [31:0] off;
    rle_in_t     w;
    n_items = $urandom_range(1, 6);
    sel = $urandom_range(0, 9);
    if (sel == 0) off = 32'hffff_ffff - $urandom_range(0, 300);
    else if (sel == 1) off = '0;
    else off = $urandom;
    for (int i = 0; i < n_items; i++) begin
      w.value     = $urandom;
      w.job_first = (i == 0);
      w.job_last  = (i == n_items - 1);
      sel = $urandom_range(0, 99);
      if (cum_mode) begin
        if (i != 0) begin
          if (sel < 5) off = off - 32'd1 - $urandom_range(0, 50);
          else if (sel < 10) off = off + 32'd65 + $urandom_range(0, 1000);
          else if (sel < 20) off = off + $urandom_range(0, MAX_RUN);
          else off = off + $urandom_range(0, 8);
        end
        w.count = off;
      end else begin
        if (sel < 4) w.count = $urandom;
        else if (sel < 8) w.count = MAX_RUN + 1;
        else if (sel < 18) w.count = $urandom_range(0, MAX_RUN);
        else w.count = $urandom_range(0, 8);
      end
      offer_word(w, 1'b0, 1'b0, KIND_ELEMENT);
    end
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    rle_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (elements_due.size() == 0) begin
        $error("unexpected output word %h", out_word_o);
        failures++;
      end else begin
        want = elements_due.pop_front();
        if (out_word_o.element !== want.element) begin
          $error("element: expected %h, got %h", want.element, out_word_o.element);
          failures++;
        end
        if (out_word_o.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_word_o.kind);
          failures++;
        end
        if (out_word_o.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, out_word_o.run_end);
          failures++;
        end
        if (out_word_o.job_end !== want.job_end) begin
          $error("job_end: expected %0b, got %0b", want.job_end, out_word_o.job_end);
          failures++;
        end
      end
    end
  end

  initial begin
    rle_in_t w;
    int      p;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_stall_i  = 1'b0;
    cum_mode     = 1'b0;
    last_offset  = '0;
    drop_job     = 1'b0;
    live_items   = 0;
    failures     = 0;
    cycles       = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b0;
    hold_ack     = 1'b0;
    hold_left    = 0;

    dir_rows = '{
      '{1'b0, 32'd0, 32'h1234_5678, 1'b1, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd0, 32'hffff_ffff, 1'b0, 1'b1, 1'b1, 1'b1, KIND_MARKER},
      '{1'b0, 32'd1, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd64, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd65, 32'hdead_beef, 1'b0, 1'b0, 1'b1, 1'b1, KIND_ERROR},
      '{1'b0, 32'd3, 32'h0000_0001, 1'b0, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd2, 32'h0000_0002, 1'b0, 1'b1, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'hffff_ffff, 32'h0000_0003, 1'b1, 1'b0, 1'b1, 1'b1, KIND_ERROR},
      '{1'b0, 32'd0, 32'h0000_0004, 1'b0, 1'b1, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd5, 32'ha5a5_a5a5, 1'b1, 1'b0, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd2, 32'h5a5a_5a5a, 1'b0, 1'b1, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd100, 32'hffff_ffff, 1'b1, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd103, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd103, 32'h0000_0002, 1'b0, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd167, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd166, 32'h0000_0004, 1'b0, 1'b0, 1'b1, 1'b1, KIND_ERROR},
      '{1'b1, 32'd200, 32'h0000_0005, 1'b0, 1'b1, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'hffff_ffff, 32'h0000_0006, 1'b1, 1'b1, 1'b1, 1'b1, KIND_MARKER},
      '{1'b1, 32'd0, 32'h0000_0007, 1'b1, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'd65, 32'h0000_0008, 1'b0, 1'b1, 1'b1, 1'b1, KIND_ERROR},
      '{1'b1, 32'hffff_ffbf, 32'h0000_0009, 1'b1, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'hffff_ffff, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 1'b0, KIND_ELEMENT},
      '{1'b1, 32'hffff_ffff, 32'h0000_000a, 1'b0, 1'b1, 1'b1, 1'b1, KIND_MARKER},
      '{1'b1, 32'h0000_0010, 32'h0000_000b, 1'b1, 1'b0, 1'b1, 1'b0, KIND_ELEMENT},
      '{1'b0, 32'd1, 32'h7fff_fffe, 1'b0, 1'b1, 1'b0, 1'b0, KIND_ELEMENT}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cum_mode) write_mode(dir_rows[i].mode);
      w.count     = dir_rows[i].count;
      w.value     = dir_rows[i].value;
      w.job_first = dir_rows[i].first;
      w.job_last  = dir_rows[i].last;
      offer_word(w, dir_rows[i].typed, dir_rows[i].one, dir_rows[i].kind);
    end

    for (p = 0; p < 8; p++) begin
      write_mode(p[0] ^ p[2]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      if (p == 0 || p == 5) hold_req = !hold_req;
      live_items = 0;
      while (live_items < 48) begin
        if ($urandom_range(0, 99) < 15) begin
          w.count     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12);
          w.value     = $urandom;
          w.job_first = 1'($urandom_range(0, 1));
          w.job_last  = 1'($urandom_range(0, 1));
          offer_word(w, 1'b0, 1'b0, KIND_ELEMENT);
        end else begin
          send_job();
        end
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (elements_due.size() != 0) begin
      $error("%0d expected words never arrived", elements_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS run_length_expand");
    end else begin
      $display("FAIL run_length_expand");
    end
    $finish;
  end

endmodule
